### hdl/button_click_classifier_assert.svh
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Concurrent check on the rising edge of clk, off while rst is high.
`define BCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose result is checked at the next clock edge, off while rst is high.
`define BCC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } bcc_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL_MASK = 2'd0,
    REG_LONG_THRESHOLD    = 2'd1,
    REG_SHORT_THRESHOLD   = 2'd2,
    REG_DOUBLE_WINDOW     = 2'd3
  } bcc_reg_t;

  // One button's entry in the state memory.
  typedef struct packed {
    logic                   detect_started;
    logic                   last_pressed;
    logic [COUNT_WIDTH-1:0] hold_ticks;
    logic [1:0]             click_count;
    logic [COUNT_WIDTH-1:0] gap_ticks;
  } bcc_state_t;

  // Thresholds that the update logic needs.
  typedef struct packed {
    logic [CFG_W-1:0] long_threshold;
    logic [CFG_W-1:0] short_threshold;
    logic [CFG_W-1:0] double_window;
  } bcc_thresh_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

### hdl/bcc_ram.sv
`default_nettype none

module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when read and write hit the same entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### hdl/bcc_update.sv
`default_nettype none

module bcc_update (
  input  wire bcc_pkg::bcc_state_t  cur,
  input  wire logic                 pressed,
  input  wire bcc_pkg::bcc_thresh_t thr,
  output bcc_pkg::bcc_state_t       nxt,
  output bcc_pkg::bcc_event_t       code
);

  import bcc_pkg::*;

  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] gap_inc;
  logic [1:0]             click_inc;

  always_comb begin
    hold_inc  = sat_inc(cur.hold_ticks);
    gap_inc   = sat_inc(cur.gap_ticks);
    click_inc = (cur.click_count == 2'd3) ? 2'd3 : cur.click_count + 2'd1;
    nxt       = cur;
    code      = EV_NONE;

    if (!cur.detect_started && pressed) begin
      // Held since start-up: only remember the level.
      nxt.last_pressed = 1'b1;
    end else begin
      if (pressed) begin
        if (!cur.last_pressed) begin
          nxt.hold_ticks = '0;
        end else begin
          nxt.hold_ticks = hold_inc;
          if (32'(thr.long_threshold) < 32'(hold_inc)) begin
            code = EV_LONG;
          end
        end
      end else if (cur.last_pressed) begin
        if ((32'(cur.hold_ticks) < 32'(thr.long_threshold)) &&
            (32'(cur.hold_ticks) > 32'(thr.short_threshold))) begin
          nxt.hold_ticks  = '0;
          nxt.click_count = click_inc;
          nxt.gap_ticks   = '0;
          if (click_inc > 2'd1) begin
            nxt.click_count = 2'd0;
            code            = EV_DOUBLE;
          end
        end
      end else begin
        nxt.detect_started = 1'b1;
        if (cur.click_count == 2'd1) begin
          nxt.gap_ticks = gap_inc;
          if (32'(gap_inc) > 32'(thr.double_window)) begin
            nxt.click_count = 2'd0;
            nxt.gap_ticks   = '0;
            code            = EV_SINGLE;
          end
        end
      end
      nxt.last_pressed = pressed;
    end
  end

endmodule

`default_nettype wire

### hdl/button_click_classifier.sv
`default_nettype none

// Button click classifier. Each input transfer is one tick sample of one
// button's raw pin level (s_tdata: bits 2:0 button_index, bit 3 pin_level);
// each one yields exactly one output transfer carrying the button index in
// m_tdata bits 2:0 and the event in m_tuser (0 none, 1 single click, 2 double
// click, 3 long hold), in input order. Per-button state lives in a small
// synchronous RAM: a sample reads its button's entry when it is accepted,
// and when stage 1 advances the entry is updated and written back and the
// output register is loaded. One sample per clock is sustained while the
// output is not stalled; the loop that sets this figure is the state RAM's
// read-modify-write, which a bypass register closes when consecutive
// samples hit the same button. A sample passes through the stage 1
// registers and then the output register, whose valid bit drives m_tvalid.
// Reset clears a valid bit per entry, so there is no clearing pass.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module button_click_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input samples.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [2:0] button_index, [3] pin_level
  // Output events.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [7:0]                  m_tdata,   // [2:0] event_button
  output logic      [1:0]                  m_tuser,   // [1:0] event_code
  // Configuration writes.
  input  wire logic                        cfg_we,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcc_pkg::CFG_W-1:0]   cfg_data
);

  import bcc_pkg::*;

  `include "button_click_classifier_assert.svh"

  // Configuration registers.
  logic [7:0]       active_level_mask;
  logic [CFG_W-1:0] long_threshold;
  logic [CFG_W-1:0] short_threshold;
  logic [CFG_W-1:0] double_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level_mask <= 8'd1;
      long_threshold    <= CFG_W'(200);
      short_threshold   <= CFG_W'(3);
      double_window     <= CFG_W'(50);
    end else if (cfg_we) begin
      unique case (bcc_reg_t'(cfg_index))
        REG_ACTIVE_LEVEL_MASK: active_level_mask <= cfg_data[7:0];
        REG_LONG_THRESHOLD:    long_threshold    <= cfg_data;
        REG_SHORT_THRESHOLD:   short_threshold   <= cfg_data;
        REG_DOUBLE_WINDOW:     double_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control. Stage 1 holds the sample whose RAM read
  // is in flight; it moves on when the output register is free or drains.
  logic s_accept;
  logic adv;
  logic s1_valid;
  logic out_valid;

  assign adv      = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign s_accept = s_tvalid && s_tready;

  // Stage 1 registers.
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_level;
  logic              s1_entry_valid;
  logic [NUM_BUTTONS-1:0] entry_valid;

  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_in_range;

  assign in_addr     = s_tdata[ADDR_W-1:0];
  assign s1_addr     = s1_idx[ADDR_W-1:0];
  assign s1_in_range = (32'(s1_idx) < NUM_BUTTONS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_idx         <= s_tdata[IDX_W-1:0];
      s1_level       <= s_tdata[3];
      s1_entry_valid <= entry_valid[in_addr];
    end
  end

  // State RAM and its write-back path.
  bcc_state_t ram_rdata;
  bcc_state_t upd_next;
  bcc_event_t upd_code;
  logic       ram_we;

  assign ram_we = adv && s1_in_range;

  bcc_ram #(
    .WIDTH ($bits(bcc_state_t)),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (upd_next),
    .re    (s_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // The bypass holds the most recent write. A read issued at the same edge
  // as that write saw the old entry, so a matching address takes the bypass.
  logic              byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  bcc_state_t        byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (ram_we) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_addr <= s1_addr;
      byp_data <= upd_next;
    end
  end

  bcc_state_t  cur_state;
  bcc_thresh_t thr;
  logic        pressed;

  always_comb begin
    if (byp_valid && (byp_addr == s1_addr)) begin
      cur_state = byp_data;
    end else if (s1_entry_valid) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
    pressed             = (s1_level == active_level_mask[s1_idx]);
    thr.long_threshold  = long_threshold;
    thr.short_threshold = short_threshold;
    thr.double_window   = double_window;
  end

  bcc_update u_update (
    .cur     (cur_state),
    .pressed (pressed),
    .thr     (thr),
    .nxt     (upd_next),
    .code    (upd_code)
  );

  // Output register.
  logic [IDX_W-1:0] out_button;
  bcc_event_t       out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_button <= s1_idx;
      out_code   <= s1_in_range ? upd_code : EV_NONE;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(8 - IDX_W){1'b0}}, out_button};
  assign m_tuser  = out_code;

  // A double click always leaves the click count cleared.
  `BCC_ASSERT(a_double_clears,
              !(ram_we && upd_code == EV_DOUBLE) || upd_next.click_count == 2'd0,
              "double click left click count set")
  // The input side stalls only behind a full stage 1 and a blocked output.
  `BCC_ASSERT(a_stall_cause,
              s_tready || (s1_valid && out_valid && !m_tready),
              "input stalled without cause")
  // Every write-back lands in the bypass register.
  `BCC_ASSERT_NEXT(a_bypass_load, ram_we,
                   byp_valid && byp_addr == $past(s1_addr),
                   "bypass missed a write")

endmodule

`default_nettype wire
